// ===== rtl/core/tpr_pkg.sv =====
package tpr_pkg;

  // Field widths
  localparam int TURNS_W    = 13;
  localparam int COUNT_W    = 11;
  localparam int OUT_W      = 32;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 24;
  localparam int STEP_W     = 5;

  // Wide intermediate width for products and sums
  localparam int PW = 51;

  // Encoder scale: micrometres per degree in Q6
  localparam logic [21:0] UM_PER_DEG_Q6 = 22'd45797;

  // Profile constants
  localparam logic [23:0] SHORT_MOVE_UM   = 24'd500000;
  localparam logic [21:0] CRUISE_UM_PER_MS = 22'd500;
  localparam logic [21:0] LONG_DECEL_RATE = 22'd1000;
  localparam logic [31:0] DECEL_CLAMP_MS  = 32'd1048576;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_ACCEL_TIME  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_CRUISE_TIME = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_ACCEL_DIST  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_CRUISE_DIST = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_TOTAL_DIST  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_KP          = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD   = 3'd6;

  typedef enum logic [1:0] {
    PH_STOP   = 2'd0,
    PH_ACCEL  = 2'd1,
    PH_CRUISE = 2'd2,
    PH_DECEL  = 2'd3
  } phase_t;

  typedef enum logic [4:0] {
    OP_ACCEPT,
    OP_CHECK,
    OP_DEG,
    OP_MUL_POS_L,
    OP_POS_L,
    OP_POS_R,
    OP_DEC_SQ,
    OP_DEC_LIN,
    OP_DEC_SUM,
    OP_DEC_SP,
    OP_ACC_SQ,
    OP_ACC_SP,
    OP_CRU_MUL,
    OP_CRU_SP,
    OP_DRV_L,
    OP_DRV_R,
    OP_OUT
  } op_t;

  typedef enum logic [2:0] {
    J_NEXT,
    J_GOTO,
    J_WAIT_IN,
    J_IF_IDLE,
    J_PHASE,
    J_WAIT_OUT
  } jump_t;

  typedef logic [STEP_W-1:0] step_t;

  // Program addresses
  localparam step_t S_IDLE    = 5'd0;
  localparam step_t S_CHECK   = 5'd1;
  localparam step_t S_DEG     = 5'd2;
  localparam step_t S_MUL_L   = 5'd3;
  localparam step_t S_POS_L   = 5'd4;
  localparam step_t S_POS_R   = 5'd5;
  localparam step_t S_DEC_SQ  = 5'd6;
  localparam step_t S_DEC_LIN = 5'd7;
  localparam step_t S_DEC_SUM = 5'd8;
  localparam step_t S_DEC_SP  = 5'd9;
  localparam step_t S_ACC_SQ  = 5'd10;
  localparam step_t S_ACC_SP  = 5'd11;
  localparam step_t S_CRU_MUL = 5'd12;
  localparam step_t S_CRU_SP  = 5'd13;
  localparam step_t S_DRV_L   = 5'd14;
  localparam step_t S_DRV_R   = 5'd15;
  localparam step_t S_OUT     = 5'd16;

  typedef struct packed {
    op_t   op;
    jump_t jmp;
    step_t target;
  } ucode_t;

  typedef struct packed {
    logic   in_fire;
    logic   active;
    phase_t phase;
    logic   out_busy;
  } seq_cond_t;

  function automatic ucode_t ucode_rom(input step_t step);
    ucode_t w;
    case (step)
      S_IDLE:    w = '{OP_ACCEPT,    J_WAIT_IN,  S_CHECK};
      S_CHECK:   w = '{OP_CHECK,     J_IF_IDLE,  S_OUT};
      S_DEG:     w = '{OP_DEG,       J_NEXT,     S_IDLE};
      S_MUL_L:   w = '{OP_MUL_POS_L, J_NEXT,     S_IDLE};
      S_POS_L:   w = '{OP_POS_L,     J_NEXT,     S_IDLE};
      S_POS_R:   w = '{OP_POS_R,     J_PHASE,    S_IDLE};
      S_DEC_SQ:  w = '{OP_DEC_SQ,    J_NEXT,     S_IDLE};
      S_DEC_LIN: w = '{OP_DEC_LIN,   J_NEXT,     S_IDLE};
      S_DEC_SUM: w = '{OP_DEC_SUM,   J_NEXT,     S_IDLE};
      S_DEC_SP:  w = '{OP_DEC_SP,    J_GOTO,     S_DRV_L};
      S_ACC_SQ:  w = '{OP_ACC_SQ,    J_NEXT,     S_IDLE};
      S_ACC_SP:  w = '{OP_ACC_SP,    J_GOTO,     S_DRV_L};
      S_CRU_MUL: w = '{OP_CRU_MUL,   J_NEXT,     S_IDLE};
      S_CRU_SP:  w = '{OP_CRU_SP,    J_GOTO,     S_DRV_L};
      S_DRV_L:   w = '{OP_DRV_L,     J_NEXT,     S_IDLE};
      S_DRV_R:   w = '{OP_DRV_R,     J_NEXT,     S_IDLE};
      S_OUT:     w = '{OP_OUT,       J_WAIT_OUT, S_IDLE};
      default:   w = '{OP_ACCEPT,    J_GOTO,     S_IDLE};
    endcase
    return w;
  endfunction

  // Clamp a wide signed value to signed 32 bits
  function automatic logic signed [OUT_W-1:0] sat32(input logic signed [PW-1:0] v);
    logic signed [OUT_W-1:0] r;
    if (v[PW-1:OUT_W-1] == {(PW-OUT_W+1){v[PW-1]}}) begin
      r = v[OUT_W-1:0];
    end else if (v[PW-1]) begin
      r = {1'b1, {(OUT_W-1){1'b0}}};
    end else begin
      r = {1'b0, {(OUT_W-1){1'b1}}};
    end
    return r;
  endfunction

endpackage

// ===== rtl/core/tpr_tick_if.sv =====
interface tpr_tick_if import tpr_pkg::*; ();
  logic                       valid;
  logic                       ready;
  logic signed [TURNS_W-1:0]  turns_left;
  logic        [COUNT_W-1:0]  count_left;
  logic signed [TURNS_W-1:0]  turns_right;
  logic        [COUNT_W-1:0]  count_right;

  modport source (
    output valid, turns_left, count_left, turns_right, count_right,
    input  ready
  );

  modport sink (
    input  valid, turns_left, count_left, turns_right, count_right,
    output ready
  );
endinterface

// ===== rtl/core/tpr_result_if.sv =====
interface tpr_result_if import tpr_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic signed [OUT_W-1:0]  setpoint_um;
  logic signed [OUT_W-1:0]  drive_left;
  logic signed [OUT_W-1:0]  drive_right;
  logic        [1:0]        phase;

  modport source (
    output valid, setpoint_um, drive_left, drive_right, phase,
    input  ready
  );

  modport sink (
    input  valid, setpoint_um, drive_left, drive_right, phase,
    output ready
  );
endinterface

// ===== rtl/core/tpr_seq.sv =====
module tpr_seq import tpr_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  seq_cond_t cond,
  output ucode_t    uc
);

  step_t step;
  step_t step_next;

  assign uc = ucode_rom(step);

  always_comb begin
    step_next = step + 5'd1;
    case (uc.jmp)
      J_NEXT:     step_next = step + 5'd1;
      J_GOTO:     step_next = uc.target;
      J_WAIT_IN:  step_next = cond.in_fire ? uc.target : step;
      J_IF_IDLE:  step_next = cond.active ? step + 5'd1 : uc.target;
      J_PHASE: begin
        case (cond.phase)
          PH_ACCEL:  step_next = S_ACC_SQ;
          PH_CRUISE: step_next = S_CRU_MUL;
          default:   step_next = step + 5'd1;
        endcase
      end
      J_WAIT_OUT: step_next = cond.out_busy ? step : uc.target;
      default:    step_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      step <= S_IDLE;
    end else begin
      step <= step_next;
    end
  end

  // The output wait step holds while a result is still pending
  a_wait_holds: assert property (@(posedge clk) disable iff (rst)
    (uc.jmp == J_WAIT_OUT && cond.out_busy) |=> step == $past(step))
    else $error("sequencer left output wait while result still pending");

endmodule

// ===== rtl/core/trapezoid_profile_p_regulator.sv =====
// Channel   Dir  Payload                                         Transfer
// tick      in   turns_left, count_left, turns_right, count_right  valid & ready
// result    out  setpoint_um, drive_left, drive_right, phase       valid & ready
// cfg       in   cfg_index, cfg_data                               cfg_we
//
// A tick runs from the transfer through check, degree, position, setpoint and drive
// steps to the result register in accelerate, cruise or decelerate, and straight
// to the output step when stopped. The steps share one multiplier, used at most
// once per step. The result sits in an output register; the next tick is
// taken once the program returns to its idle step, and the output step
// waits while a result is not taken.
// Reset (rst, synchronous) loads the register defaults, clears elapsed time
// and both latched positions, and drops any pending result.
module trapezoid_profile_p_regulator import tpr_pkg::*; (
  input  logic                   clk,
  input  logic                   rst,
  tpr_tick_if.sink               tick,
  tpr_result_if.source           result,
  input  logic                   cfg_we,
  input  logic [CFG_IDX_W-1:0]   cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data
);

  // Configuration registers
  logic [15:0] accel_time_ms;
  logic [15:0] cruise_time_ms;
  logic [23:0] accel_dist_um;
  logic [23:0] cruise_dist_um;
  logic [23:0] total_dist_um;
  logic [15:0] kp_q8;
  logic [23:0] threshold_um;

  // Persistent state
  logic [31:0]              elapsed_ms;
  logic signed [OUT_W-1:0]  last_pos_left;
  logic signed [OUT_W-1:0]  last_pos_right;

  // Per-tick working registers
  logic signed [TURNS_W-1:0] turns_l;
  logic signed [TURNS_W-1:0] turns_r;
  logic        [COUNT_W-1:0] cnt_l;
  logic        [COUNT_W-1:0] cnt_r;
  logic signed [22:0]        deg_l;
  logic signed [22:0]        deg_r;
  logic        [20:0]        d_ms;
  logic                      act;
  phase_t                    ph;
  logic signed [PW-1:0]      p;
  logic signed [43:0]        acc;
  logic signed [OUT_W-1:0]   sp;
  logic signed [OUT_W-1:0]   drv_l;

  ucode_t    uc;
  seq_cond_t cond;

  logic in_fire;
  logic out_busy;
  logic active_now;
  logic short_move;

  logic signed [33:0] rem_l;
  logic signed [33:0] rem_r;
  logic signed [33:0] thr_s;
  logic        [16:0] ac_ms;
  logic        [31:0] d_full;
  phase_t             ph_now;

  logic signed [22:0] deg_l_now;
  logic signed [22:0] deg_r_now;

  logic signed [33:0] mul_a;
  logic signed [21:0] mul_b;
  logic signed [55:0] prod;
  logic signed [32:0] err_l;
  logic signed [32:0] err_r;
  logic        [15:0] t_cru;
  logic        [43:0] dec_base;

  tpr_seq u_seq (
    .clk  (clk),
    .rst  (rst),
    .cond (cond),
    .uc   (uc)
  );

  assign tick.ready = (uc.op == OP_ACCEPT);
  assign in_fire    = tick.valid && tick.ready;
  assign out_busy   = result.valid && !result.ready;

  assign cond.in_fire  = in_fire;
  assign cond.active   = active_now;
  assign cond.phase    = ph;
  assign cond.out_busy = out_busy;

  // Remaining distance against the positions latched at the last regulation
  assign thr_s      = $signed({10'b0, threshold_um});
  assign rem_l      = $signed({10'b0, total_dist_um}) - 34'(last_pos_left);
  assign rem_r      = $signed({10'b0, total_dist_um}) - 34'(last_pos_right);
  assign active_now = (rem_l > thr_s) || (rem_r > thr_s);
  assign short_move = (total_dist_um <= SHORT_MOVE_UM);

  // Phase from elapsed time; boundary time falls into decelerate
  assign ac_ms  = {1'b0, accel_time_ms} + {1'b0, cruise_time_ms};
  assign d_full = elapsed_ms - {15'b0, ac_ms};

  always_comb begin
    if (elapsed_ms < {16'b0, accel_time_ms}) begin
      ph_now = PH_ACCEL;
    end else if (elapsed_ms < {15'b0, ac_ms}) begin
      ph_now = PH_CRUISE;
    end else begin
      ph_now = PH_DECEL;
    end
  end

  // Degrees: turns * 360 plus quarter of count + 1
  assign deg_l_now = 23'(turns_l) * $signed(23'd360)
                   + $signed({11'b0, 12'({1'b0, cnt_l} + 12'd1) >> 2});
  assign deg_r_now = 23'(turns_r) * $signed(23'd360)
                   + $signed({11'b0, 12'({1'b0, cnt_r} + 12'd1) >> 2});

  assign err_l    = 33'(sp) - 33'(last_pos_left);
  assign err_r    = 33'(sp) - 33'(last_pos_right);
  assign t_cru    = elapsed_ms[15:0] - accel_time_ms;
  assign dec_base = short_move ? {18'b0, accel_dist_um, 2'b0}
                               : {17'b0, 25'({1'b0, accel_dist_um} + {1'b0, cruise_dist_um}),
                                  2'b0};

  // Shared multiplier operand select
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (uc.op)
      OP_MUL_POS_L: begin
        mul_a = 34'(deg_l);
        mul_b = $signed(UM_PER_DEG_Q6);
      end
      OP_POS_L: begin
        mul_a = 34'(deg_r);
        mul_b = $signed(UM_PER_DEG_Q6);
      end
      OP_DEC_SQ: begin
        mul_a = $signed({13'b0, d_ms});
        mul_b = $signed({1'b0, d_ms});
      end
      OP_DEC_LIN: begin
        mul_a = $signed({13'b0, d_ms});
        mul_b = short_move ? $signed({6'b0, accel_time_ms}) : $signed(LONG_DECEL_RATE);
      end
      OP_ACC_SQ: begin
        mul_a = $signed({18'b0, elapsed_ms[15:0]});
        mul_b = $signed({6'b0, elapsed_ms[15:0]});
      end
      OP_CRU_MUL: begin
        mul_a = $signed({18'b0, t_cru});
        mul_b = $signed(CRUISE_UM_PER_MS);
      end
      OP_DRV_L: begin
        mul_a = 34'(err_l);
        mul_b = $signed({6'b0, kp_q8});
      end
      OP_DRV_R: begin
        mul_a = 34'(err_r);
        mul_b = $signed({6'b0, kp_q8});
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign prod = mul_a * mul_b;

  // Control and persistent state
  always_ff @(posedge clk) begin
    if (rst) begin
      accel_time_ms  <= 16'd1000;
      cruise_time_ms <= 16'd0;
      accel_dist_um  <= 24'd250000;
      cruise_dist_um <= 24'd0;
      total_dist_um  <= 24'd0;
      kp_q8          <= 16'd0;
      threshold_um   <= 24'd10000;
      elapsed_ms     <= '0;
      last_pos_left  <= '0;
      last_pos_right <= '0;
      result.valid   <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_ACCEL_TIME:  accel_time_ms  <= cfg_data[15:0];
          REG_CRUISE_TIME: cruise_time_ms <= cfg_data[15:0];
          REG_ACCEL_DIST:  accel_dist_um  <= cfg_data;
          REG_CRUISE_DIST: cruise_dist_um <= cfg_data;
          REG_TOTAL_DIST:  total_dist_um  <= cfg_data;
          REG_KP:          kp_q8          <= cfg_data[15:0];
          REG_THRESHOLD:   threshold_um   <= cfg_data;
          default: ;
        endcase
      end

      // Advance time on every tick, holding at the top
      if (in_fire && (elapsed_ms != '1)) begin
        elapsed_ms <= elapsed_ms + 32'd1;
      end

      // Latch positions only on a regulating tick
      if (uc.op == OP_POS_L) begin
        last_pos_left <= sat32(p >>> 6);
      end
      if (uc.op == OP_POS_R) begin
        last_pos_right <= sat32(p >>> 6);
      end

      if (uc.op == OP_OUT && !out_busy) begin
        result.valid <= 1'b1;
      end else if (result.ready) begin
        result.valid <= 1'b0;
      end
    end
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    case (uc.op)
      OP_ACCEPT: begin
        if (in_fire) begin
          turns_l <= tick.turns_left;
          cnt_l   <= tick.count_left;
          turns_r <= tick.turns_right;
          cnt_r   <= tick.count_right;
        end
      end
      OP_CHECK: begin
        act  <= active_now;
        ph   <= ph_now;
        d_ms <= (d_full > DECEL_CLAMP_MS) ? DECEL_CLAMP_MS[20:0] : d_full[20:0];
      end
      OP_DEG: begin
        deg_l <= deg_l_now;
        deg_r <= deg_r_now;
      end
      OP_MUL_POS_L: p <= prod[PW-1:0];
      OP_POS_L:     p <= prod[PW-1:0];
      OP_DEC_SQ:    p <= prod[PW-1:0];
      OP_DEC_LIN: begin
        acc <= $signed(dec_base) - $signed(p[43:0]);
        p   <= prod[PW-1:0];
      end
      OP_DEC_SUM:   acc <= acc + $signed({p[42:0], 1'b0});
      OP_DEC_SP:    sp  <= sat32(PW'(acc >>> 2));
      OP_ACC_SQ:    p   <= prod[PW-1:0];
      OP_ACC_SP:    sp  <= sat32(p >>> 2);
      OP_CRU_MUL:   p   <= prod[PW-1:0];
      OP_CRU_SP:    sp  <= sat32(p + $signed({27'b0, accel_dist_um}));
      OP_DRV_L:     p   <= prod[PW-1:0];
      OP_DRV_R: begin
        drv_l <= sat32(p >>> 8);
        p     <= prod[PW-1:0];
      end
      OP_OUT: begin
        // Load the result register once the previous result is taken
        if (!out_busy) begin
          result.setpoint_um <= act ? sp : '0;
          result.drive_left  <= act ? drv_l : '0;
          result.drive_right <= act ? sat32(p >>> 8) : '0;
          result.phase       <= act ? ph : PH_STOP;
        end
      end
      default: ;
    endcase
  end

  a_time_advance: assert property (@(posedge clk) disable iff (rst)
    (in_fire && elapsed_ms != '1) |=> elapsed_ms == $past(elapsed_ms) + 32'd1)
    else $error("elapsed time did not advance on a tick");

  a_stop_zero: assert property (@(posedge clk) disable iff (rst)
    (result.valid && result.phase == PH_STOP)
      |-> (result.drive_left == '0 && result.drive_right == '0 && result.setpoint_um == '0))
    else $error("stopped result carries nonzero values");

  a_pos_latch: assert property (@(posedge clk) disable iff (rst)
    ($past(!rst) && !$stable(last_pos_left)) |-> $past(uc.op) == OP_POS_L)
    else $error("left position changed outside its latch step");

  a_accel_positive: assert property (@(posedge clk) disable iff (rst)
    (result.valid && result.phase == PH_ACCEL) |-> !result.setpoint_um[OUT_W-1])
    else $error("negative setpoint during acceleration");

endmodule

// ===== test/tb_trapezoid_profile_p_regulator.sv =====
`timescale 1ns / 1ps

module tb_trapezoid_profile_p_regulator;
  import tpr_pkg::*;

  // One 1 ms tick: both wheels' turn and quadrature counts
  typedef struct {
    logic signed [TURNS_W-1:0] turns_l;
    logic        [COUNT_W-1:0] count_l;
    logic signed [TURNS_W-1:0] turns_r;
    logic        [COUNT_W-1:0] count_r;
  } tick_t;

  // What the regulator must answer for one tick
  typedef struct {
    logic signed [OUT_W-1:0] setpoint;
    logic signed [OUT_W-1:0] drive_l;
    logic signed [OUT_W-1:0] drive_r;
    phase_t                  phase;
  } regulation_t;

  localparam int RANDOM_SETTINGS  = 10;
  localparam int TICKS_PER_SETTING = 85;
  localparam int IDLE_PCT         = 31;
  localparam int SETTLE_CYCLES    = 24;   // longer than a decelerate tick

  logic                  clk = 1'b0;
  logic                  rst;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  tpr_tick_if   tick_ch();
  tpr_result_if result_ch();

  trapezoid_profile_p_regulator uut (
    .clk       (clk),
    .rst       (rst),
    .tick      (tick_ch),
    .result    (result_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // Shadow copy of the profile registers
  logic [15:0] cfg_accel_ms;
  logic [15:0] cfg_cruise_ms;
  logic [23:0] cfg_accel_um;
  logic [23:0] cfg_cruise_um;
  logic [23:0] cfg_total_um;
  logic [15:0] cfg_kp;
  logic [23:0] cfg_thresh_um;

  // Profile state: time since reset and positions latched at the last regulation
  logic        [31:0]    elapsed_ms;
  logic signed [OUT_W-1:0] held_pos_l;
  logic signed [OUT_W-1:0] held_pos_r;

  tick_t       pending_ticks[$];
  regulation_t awaited_results[$];

  int errors          = 0;
  int transfers       = 0;
  int results_checked = 0;
  int ticks_queued    = 0;
  int settings_loaded = 0;
  int phase_seen[4]   = '{0, 0, 0, 0};

  // Hold both sides busy-free through one long stretch of the run
  logic calm;
  assign calm = (transfers >= 300) && (transfers < 440);

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  task automatic report_error(input string msg);
    $display("MISMATCH at %0t ns: %s", $time, msg);
    errors++;
  endtask

  task automatic check_field(input string name, input logic signed [OUT_W-1:0] got,
                             input logic signed [OUT_W-1:0] want);
    if (got !== want)
      report_error($sformatf("result %0d %s: got %0d, want %0d",
                             results_checked, name, got, want));
  endtask

  // ---------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------

  function automatic logic signed [OUT_W-1:0] clamp32(input longint v);
    if (v > 64'sh7FFF_FFFF) return 32'sh7FFF_FFFF;
    if (v < -64'sh8000_0000) return 32'sh8000_0000;
    return v[OUT_W-1:0];
  endfunction

  // Encoder reading to micrometres: whole degrees scaled by the Q6 factor.
  // Counts above one revolution are used as they come.
  function automatic logic signed [OUT_W-1:0] wheel_um(input logic signed [TURNS_W-1:0] turns,
                                                        input logic [COUNT_W-1:0] count);
    longint deg;
    deg = longint'(turns) * 360 + (longint'(count) + 1) / 4;
    return clamp32((deg * longint'(UM_PER_DEG_Q6)) >>> 6);
  endfunction

  function automatic logic signed [OUT_W-1:0] gain_drive(input logic signed [OUT_W-1:0] sp,
                                                          input logic signed [OUT_W-1:0] pos);
    return clamp32((longint'(cfg_kp) * (longint'(sp) - longint'(pos))) >>> 8);
  endfunction

  // Advance the profile by one tick and work out the answer to it
  function automatic regulation_t regulate_tick(input tick_t tk);
    regulation_t r;
    longint t, a, ac, d, sp;
    r.setpoint = '0;
    r.drive_l  = '0;
    r.drive_r  = '0;
    r.phase    = PH_STOP;
    if (elapsed_ms != 32'hFFFF_FFFF) elapsed_ms = elapsed_ms + 32'd1;
    // Regulate while either wheel still lacks more than the threshold
    if (longint'(cfg_total_um) - longint'(held_pos_l) > longint'(cfg_thresh_um) ||
        longint'(cfg_total_um) - longint'(held_pos_r) > longint'(cfg_thresh_um)) begin
      t  = longint'(elapsed_ms);
      a  = longint'(cfg_accel_ms);
      ac = a + longint'(cfg_cruise_ms);
      if (t < a) begin
        r.phase = PH_ACCEL;
        sp = (t * t) >>> 2;
      end else if (t < ac) begin
        r.phase = PH_CRUISE;
        sp = 500 * (t - a) + longint'(cfg_accel_um);
      end else begin
        // t equal to A + C already decelerates, with d = 0
        r.phase = PH_DECEL;
        d = t - ac;
        if (d > 64'sd1048576) d = 64'sd1048576;
        if (cfg_total_um <= SHORT_MOVE_UM)
          sp = 4 * longint'(cfg_accel_um) + 2 * a * d - d * d;
        else
          sp = 4 * (longint'(cfg_accel_um) + longint'(cfg_cruise_um)) + 2000 * d - d * d;
        sp = sp >>> 2;  // floor, also for a setpoint gone negative
      end
      r.setpoint = clamp32(sp);
      held_pos_l = wheel_um(tk.turns_l, tk.count_l);
      held_pos_r = wheel_um(tk.turns_r, tk.count_r);
      r.drive_l  = gain_drive(r.setpoint, held_pos_l);
      r.drive_r  = gain_drive(r.setpoint, held_pos_r);
    end
    return r;
  endfunction

  // ---------------------------------------------------------------------
  // Tick driver: present queued ticks, predict each one at its transfer
  // ---------------------------------------------------------------------

  always @(posedge clk) begin : tick_driver
    tick_t nxt;
    tick_t sent;
    if (rst) begin
      tick_ch.valid <= 1'b0;
    end else begin
      if (tick_ch.valid && tick_ch.ready) begin
        sent.turns_l = tick_ch.turns_left;
        sent.count_l = tick_ch.count_left;
        sent.turns_r = tick_ch.turns_right;
        sent.count_r = tick_ch.count_right;
        awaited_results.push_back(regulate_tick(sent));
        transfers++;
      end
      // Advance only when the bus is free or its tick just went through
      if (!tick_ch.valid || tick_ch.ready) begin
        if (pending_ticks.size() != 0 && (calm || $urandom_range(99) >= IDLE_PCT)) begin
          nxt = pending_ticks.pop_front();
          tick_ch.valid       <= 1'b1;
          tick_ch.turns_left  <= nxt.turns_l;
          tick_ch.count_left  <= nxt.count_l;
          tick_ch.turns_right <= nxt.turns_r;
          tick_ch.count_right <= nxt.count_r;
        end else begin
          tick_ch.valid <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------
  // Result monitor: stall at random, compare each transfer with the oldest
  // expectation
  // ---------------------------------------------------------------------

  always @(posedge clk) begin : result_monitor
    regulation_t want;
    if (rst) begin
      result_ch.ready <= 1'b0;
    end else begin
      if (result_ch.valid && result_ch.ready) begin
        if (awaited_results.size() == 0) begin
          report_error("result with no tick awaiting it");
        end else begin
          want = awaited_results.pop_front();
          check_field("setpoint_um", result_ch.setpoint_um, want.setpoint);
          check_field("drive_left", result_ch.drive_left, want.drive_l);
          check_field("drive_right", result_ch.drive_right, want.drive_r);
          check_field("phase", {30'b0, result_ch.phase}, {30'b0, want.phase});
          phase_seen[want.phase]++;
        end
        results_checked++;
      end
      result_ch.ready <= calm || ($urandom_range(99) >= IDLE_PCT);
    end
  end

  // ---------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------

  task automatic queue_tick(input int tl, input int cl, input int tr, input int cr);
    tick_t tk;
    tk.turns_l = tl[TURNS_W-1:0];
    tk.count_l = cl[COUNT_W-1:0];
    tk.turns_r = tr[TURNS_W-1:0];
    tk.count_r = cr[COUNT_W-1:0];
    pending_ticks.push_back(tk);
    ticks_queued++;
  endtask

  function automatic int rand_count();
    if ($urandom_range(99) < 85) return int'($urandom_range(1439));
    return int'($urandom_range(2047, 1440));   // past one revolution
  endfunction

  // The anchor wheel takes only negative turns, so the latched positions
  // can always be brought back under a reachable target; the other wheel
  // roams the whole field.
  function automatic int rand_turns(input bit anchor);
    if (anchor) begin
      if ($urandom_range(1) != 0) return -int'($urandom_range(80, 1));
      return -int'($urandom_range(4096, 1));
    end
    if ($urandom_range(1) != 0) return int'($urandom_range(160)) - 80;
    return int'($urandom_range(8191)) - 4096;
  endfunction

  task automatic queue_random_tick();
    bit left_anchor;
    left_anchor = 1'($urandom_range(1));
    queue_tick(rand_turns(left_anchor), rand_count(), rand_turns(!left_anchor), rand_count());
  endtask

  // Write one register at the next edge; the shadow follows at once since
  // nothing is in flight while registers change
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    case (idx)
      REG_ACCEL_TIME:  cfg_accel_ms  = val[15:0];
      REG_CRUISE_TIME: cfg_cruise_ms = val[15:0];
      REG_ACCEL_DIST:  cfg_accel_um  = val;
      REG_CRUISE_DIST: cfg_cruise_um = val;
      REG_TOTAL_DIST:  cfg_total_um  = val;
      REG_KP:          cfg_kp        = val[15:0];
      REG_THRESHOLD:   cfg_thresh_um = val;
      default: ;
    endcase
  endtask

  // Load a full profile; the 16-bit registers get junk in the unused top bits
  task automatic load_profile(input int a, input int c, input int da, input int dc,
                              input int total, input int gain, input int thr);
    write_reg(REG_ACCEL_TIME, {8'($urandom_range(255)), a[15:0]});
    write_reg(REG_CRUISE_TIME, {8'($urandom_range(255)), c[15:0]});
    write_reg(REG_ACCEL_DIST, da[23:0]);
    write_reg(REG_CRUISE_DIST, dc[23:0]);
    write_reg(REG_TOTAL_DIST, total[23:0]);
    write_reg(REG_KP, {8'($urandom_range(255)), gain[15:0]});
    write_reg(REG_THRESHOLD, thr[23:0]);
    @(posedge clk);
    cfg_we <= 1'b0;
    settings_loaded++;
  endtask

  // Wait for every queued tick to transfer and every result to come back,
  // then let the block settle. Sample at the falling edge, clear of updates.
  task automatic quiesce();
    do @(negedge clk);
    while (pending_ticks.size() != 0 || tick_ch.valid || awaited_results.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // ---------------------------------------------------------------------
  // Test sequence
  // ---------------------------------------------------------------------

  initial begin : stimulus
    int a, c, da, dc, total, gain, thr;
    rst                 = 1'b1;
    cfg_we              = 1'b0;
    cfg_index           = '0;
    cfg_data            = '0;
    tick_ch.valid       = 1'b0;
    tick_ch.turns_left  = '0;
    tick_ch.count_left  = '0;
    tick_ch.turns_right = '0;
    tick_ch.count_right = '0;
    result_ch.ready     = 1'b0;
    // Register defaults and cleared profile state after reset
    cfg_accel_ms  = 16'd1000;
    cfg_cruise_ms = '0;
    cfg_accel_um  = 24'd250000;
    cfg_cruise_um = '0;
    cfg_total_um  = '0;
    cfg_kp        = '0;
    cfg_thresh_um = 24'd10000;
    elapsed_ms    = '0;
    held_pos_l    = '0;
    held_pos_r    = '0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // Walk accelerate (t 1..5), cruise (6..9), the decel boundary (10) and
    // decel, at full gain and zero threshold, with field extremes so the
    // drives saturate both ways.
    load_profile(6, 4, 9, 2000, 16777215, 65535, 0);
    queue_tick(-4096, 0, 4095, 2047);
    queue_tick(4095, 1439, -4096, 1440);
    queue_tick(0, 0, 0, 1);
    queue_tick(-1, 2047, 1, 3);
    queue_tick(4095, 0, -1, 0);
    queue_tick(-4096, 2047, 4095, 2047);
    queue_tick(17, 720, -3, 4);
    queue_tick(0, 1439, 0, 1440);
    queue_tick(-2, 2, 2, 5);
    queue_tick(-5, 100, 5, 100);
    queue_tick(1, 1, 2, 2);
    queue_tick(0, 0, 0, 0);

    // Target reached: both wheels within the threshold, so drop to stopped
    // and leave the latched positions alone whatever the encoders say
    quiesce();
    load_profile(6, 4, 9, 2000, 0, 65535, 10000);
    queue_tick(4095, 2047, 4095, 2047);
    queue_tick(-4096, 1440, 0, 0);
    queue_tick(4095, 0, -4096, 2047);

    // Short move at the 0.5 m boundary with maximum distances: two accel
    // ticks, then short decel from d = 0
    quiesce();
    load_profile(ticks_queued + 3, 0, 16777215, 16777215, 500000, 1, 0);
    queue_tick(-1, 0, -1, 1439);
    queue_tick(-3, 10, -2, 20);
    queue_tick(-1, 5, 0, 0);
    queue_tick(-4, 0, -4, 0);

    // No accel and no cruise: short decel from zero distance drives the
    // setpoint negative, where the shift must round down
    quiesce();
    load_profile(0, 0, 0, 0, 300000, 256, 0);
    queue_tick(-7, 3, -2, 1439);
    queue_tick(-1, 1440, -3, 2047);
    queue_tick(-100, 500, -9, 9);
    queue_tick(-4096, 1439, -1, 0);

    // Random settings, each started relative to the time already elapsed
    // so every one walks through its own phases
    for (int k = 0; k < RANDOM_SETTINGS; k++) begin
      quiesce();
      a     = ticks_queued + int'($urandom_range(40));
      c     = int'($urandom_range(40));
      da    = int'($urandom_range(16777215));
      dc    = int'($urandom_range(16777215));
      total = int'($urandom_range(16777215, 500001));
      gain  = int'($urandom_range(65535));
      thr   = int'($urandom_range(50000));
      case (k)
        0: begin  // longest accel and cruise, full gain
          a    = 65535;
          c    = 65535;
          gain = 65535;
        end
        1: begin  // decel only, zero gain and threshold
          a    = 0;
          c    = 0;
          gain = 0;
          thr  = 0;
        end
        2: begin  // zero target, widest threshold: mostly stopped
          c     = 65535;
          total = 0;
          thr   = 16777215;
        end
        3: begin
          total = 500000;
          da    = 16777215;
          dc    = 16777215;
        end
        4: begin
          total = 500001;
          da    = 0;
          dc    = 0;
        end
        5, 7: total = int'($urandom_range(500000, 200000));
        6:    total = 16777215;
        8:    total = int'($urandom_range(200000));
        default: ;
      endcase
      load_profile(a, c, da, dc, total, gain, thr);
      repeat (TICKS_PER_SETTING) queue_random_tick();
    end

    // Drain, with a bound in case results stop coming
    do @(negedge clk);
    while (pending_ticks.size() != 0 || tick_ch.valid);
    for (int w = 0; w < 2000 && awaited_results.size() != 0; w++) @(negedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (awaited_results.size() != 0)
      report_error($sformatf("%0d results never arrived", awaited_results.size()));

    $display("Covered %0d ticks over %0d register settings; %0d results compared.",
             transfers, settings_loaded, results_checked);
    $display("Phases seen: stopped %0d, accelerate %0d, cruise %0d, decelerate %0d.",
             phase_seen[PH_STOP], phase_seen[PH_ACCEL], phase_seen[PH_CRUISE],
             phase_seen[PH_DECEL]);
    if (errors == 0) begin
      $display("** trapezoid_profile_p_regulator: PASSED **");
    end else begin
      $display("** trapezoid_profile_p_regulator: FAILED **");
    end
    $finish;
  end

  // Hard stop far beyond the slowest correct run
  initial begin : watchdog
    #5_000_000;
    $display("Timed out with %0d ticks queued and %0d results awaited.",
             pending_ticks.size(), awaited_results.size());
    $display("** trapezoid_profile_p_regulator: FAILED **");
    $finish;
  end

endmodule
